>>> rtl/rahrt_pkg.sv
// Shared constants and helpers for the hot-row tracker.
// No dependencies; imported by the tracker top level and its checker.
package rahrt_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int ROW_BITS      = 16;
  localparam int COUNT_BITS    = 32;
  localparam int THR_BITS      = 32;

  localparam int IDX_BITS  = $clog2(TABLE_ENTRIES);
  localparam int OCC_BITS  = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_BITS  = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

  // stream packing: row | count | safe, padded to whole bytes
  localparam int IN_DATA_BITS  = ((ROW_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((ROW_BITS + COUNT_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_CNT_LSB   = ROW_BITS;
  localparam int OUT_SAFE_BIT  = ROW_BITS + COUNT_BITS;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - (ROW_BITS + COUNT_BITS + 1);

  // commands carried on in_tuser
  localparam logic CMD_ACT = 1'b0;
  localparam logic CMD_RFM = 1'b1;

  // configuration register indexes
  localparam int   CFG_IDX_BITS     = 1;
  localparam logic REG_SAFE_THR     = 1'b0;
  localparam logic REG_RESET_ON_REF = 1'b1;

  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [OCC_BITS-1:0]   occ_t;

  // saturating increment
  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
    return r;
  endfunction

endpackage

>>> rtl/row_activation_hot_row_tracker.sv
// Hot-row tracker top level: space-saving counter table with a single scan unit.
// Depends on rahrt_pkg.
// Each item passes a first scan of the occupied entries, the table update, a second scan and
//   a done state that issues the result beat.
// Items are taken one at a time: in_tready is high only when idle, not while an item is in flight.
// Reset: control and fill count cleared at once; the table counts as empty, no clearing pass.
module row_activation_hot_row_tracker
  import rahrt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [15:0] row_address
  input  logic                     in_tuser,   // [0] command
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [15:0] refresh_row, [47:16] refresh_count,
                                               // [48] safe_flag, rest zero
  output logic                     out_tuser,  // [0] refresh_valid
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [THR_BITS-1:0]      cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SCAN2 = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // table storage
  row_t   row_mem [TABLE_ENTRIES];
  count_t cnt_mem [TABLE_ENTRIES];
  row_t   rd_row_r;
  count_t rd_cnt_r;

  logic [2:0] state_r, state_nxt;
  occ_t       occ_r, occ_nxt;
  occ_t       addr_r, addr_nxt;
  logic       p_v_r, p_v_nxt;
  idx_t       p_idx_r, p_idx_nxt;
  logic [THR_BITS-1:0] thr_r, thr_nxt;
  logic       rst_ref_r, rst_ref_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  logic       cmd_r, cmd_nxt;
  row_t       row_r, row_nxt;
  logic       found_r, found_nxt;
  idx_t       match_idx_r, match_idx_nxt;
  count_t     match_cnt_r, match_cnt_nxt;
  logic       have_r, have_nxt;
  idx_t       min_idx_r, min_idx_nxt;
  count_t     min_cnt_r, min_cnt_nxt;
  idx_t       max_idx_r, max_idx_nxt;
  count_t     max_cnt_r, max_cnt_nxt;
  row_t       max_row_r, max_row_nxt;
  logic       res_valid_r, res_valid_nxt;
  row_t       res_row_r, res_row_nxt;
  count_t     res_cnt_r, res_cnt_nxt;
  logic       safe_r, safe_nxt;
  logic       out_user_r, out_user_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;

  logic       row_we, cnt_we;
  idx_t       wr_idx;
  row_t       wr_row;
  count_t     wr_cnt;
  idx_t       rd_addr;
  logic       scan_done;
  count_t     spread;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign rd_addr   = addr_r[IDX_BITS-1:0];
  assign scan_done = (addr_r == occ_r) && !p_v_r;
  assign spread    = have_r ? (max_cnt_r - min_cnt_r) : '0;

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[wr_idx] <= wr_row;
    end
    if (cnt_we) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    rd_row_r <= row_mem[rd_addr];
    rd_cnt_r <= cnt_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    addr_nxt       = addr_r;
    p_v_nxt        = 1'b0;
    p_idx_nxt      = rd_addr;
    thr_nxt        = thr_r;
    rst_ref_nxt    = rst_ref_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd_nxt        = cmd_r;
    row_nxt        = row_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    match_cnt_nxt  = match_cnt_r;
    have_nxt       = have_r;
    min_idx_nxt    = min_idx_r;
    min_cnt_nxt    = min_cnt_r;
    max_idx_nxt    = max_idx_r;
    max_cnt_nxt    = max_cnt_r;
    max_row_nxt    = max_row_r;
    res_valid_nxt  = res_valid_r;
    res_row_nxt    = res_row_r;
    res_cnt_nxt    = res_cnt_r;
    safe_nxt       = safe_r;
    out_user_nxt   = out_user_r;
    out_data_nxt   = out_data_r;
    row_we         = 1'b0;
    cnt_we         = 1'b0;
    wr_idx         = match_idx_r;
    wr_row         = row_r;
    wr_cnt         = sat_inc(match_cnt_r);

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAFE_THR:     thr_nxt = cfg_data;
        REG_RESET_ON_REF: rst_ref_nxt = cfg_data[0];
        default:          thr_nxt = thr_r;
      endcase
    end

    // scan unit: one entry compared per cycle, in the cycle after its read
    if (p_v_r) begin
      if ((state_r == S_SCAN1) && (cmd_r == CMD_ACT) && !found_r && (rd_row_r == row_r)) begin
        found_nxt     = 1'b1;
        match_idx_nxt = p_idx_r;
        match_cnt_nxt = rd_cnt_r;
      end
      if (!have_r || (rd_cnt_r < min_cnt_r)) begin
        min_idx_nxt = p_idx_r;
        min_cnt_nxt = rd_cnt_r;
      end
      if (!have_r || (rd_cnt_r > max_cnt_r)) begin
        max_idx_nxt = p_idx_r;
        max_cnt_nxt = rd_cnt_r;
        max_row_nxt = rd_row_r;
      end
      have_nxt = 1'b1;
    end

    unique case (state_r) inside
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          row_nxt   = in_tdata[ROW_BITS-1:0];
          addr_nxt  = '0;
          found_nxt = 1'b0;
          have_nxt  = 1'b0;
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1, S_SCAN2: begin
        if (addr_r != occ_r) begin
          p_v_nxt  = 1'b1;
          addr_nxt = addr_r + occ_t'(1);
        end
        if (scan_done) begin
          if (state_r == S_SCAN1) begin
            state_nxt = S_UPD;
          end else begin
            safe_nxt  = (CMP_BITS'(spread) < CMP_BITS'(thr_r));
            state_nxt = S_DONE;
          end
        end
      end
      S_UPD: begin
        res_valid_nxt = 1'b0;
        res_row_nxt   = '0;
        res_cnt_nxt   = '0;
        if (cmd_r == CMD_ACT) begin
          if (found_r) begin
            cnt_we = 1'b1;
          end else if (occ_r != occ_t'(TABLE_ENTRIES)) begin
            row_we  = 1'b1;
            cnt_we  = 1'b1;
            wr_idx  = occ_r[IDX_BITS-1:0];
            wr_cnt  = count_t'(1);
            occ_nxt = occ_r + occ_t'(1);
          end else begin
            // full: evict the smallest count
            row_we = 1'b1;
            cnt_we = 1'b1;
            wr_idx = min_idx_r;
            wr_cnt = sat_inc(min_cnt_r);
          end
        end else if (have_r) begin
          res_valid_nxt = 1'b1;
          res_row_nxt   = max_row_r;
          res_cnt_nxt   = max_cnt_r;
          cnt_we        = rst_ref_r;
          wr_idx        = max_idx_r;
          wr_cnt        = min_cnt_r;
        end
        addr_nxt  = '0;
        have_nxt  = 1'b0;
        state_nxt = S_SCAN2;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_user_nxt   = res_valid_r;
          out_data_nxt   = {{OUT_PAD_BITS{1'b0}}, safe_r, res_cnt_r, res_row_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      addr_r       <= '0;
      p_v_r        <= 1'b0;
      thr_r        <= '0;
      rst_ref_r    <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      addr_r       <= addr_nxt;
      p_v_r        <= p_v_nxt;
      thr_r        <= thr_nxt;
      rst_ref_r    <= rst_ref_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r     <= p_idx_nxt;
    cmd_r       <= cmd_nxt;
    row_r       <= row_nxt;
    found_r     <= found_nxt;
    match_idx_r <= match_idx_nxt;
    match_cnt_r <= match_cnt_nxt;
    have_r      <= have_nxt;
    min_idx_r   <= min_idx_nxt;
    min_cnt_r   <= min_cnt_nxt;
    max_idx_r   <= max_idx_nxt;
    max_cnt_r   <= max_cnt_nxt;
    max_row_r   <= max_row_nxt;
    res_valid_r <= res_valid_nxt;
    res_row_r   <= res_row_nxt;
    res_cnt_r   <= res_cnt_nxt;
    safe_r      <= safe_nxt;
    out_user_r  <= out_user_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

>>> rtl/rahrt_checker.sv
// Port-level checks for the hot-row tracker, bound to the top level.
// Depends on rahrt_pkg and row_activation_hot_row_tracker.
module rahrt_checker
  import rahrt_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic                     out_tuser
);

  // synchronous reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat pending after reset");

  // one item at a time: busy straight after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in flight");

  // activates and empty refreshes report no row and no count
  a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata[ROW_BITS-1:0] == '0) && (out_tdata[OUT_CNT_LSB +: COUNT_BITS] == '0))
    else $error("row or count reported without a refresh target");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

endmodule

bind row_activation_hot_row_tracker rahrt_checker u_rahrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
